@@ rtl/core/tli_pkg.sv @@
package tli_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  localparam int COUNT_W        = 11;
  localparam int INDEX_W        = 10;
  localparam int VAL_W          = 32;
  localparam int STATUS_W       = 2;
  localparam int DIV_STEPS      = 32;

  typedef logic signed [VAL_W-1:0] q16_t;
  typedef logic [COUNT_W-1:0]      count_t;
  typedef logic [INDEX_W-1:0]      index_t;
  typedef logic [STATUS_W-1:0]     status_t;

  localparam logic    OP_LOAD  = 1'b0;
  localparam logic    OP_QUERY = 1'b1;

  localparam status_t ST_INTERP = 2'd0;
  localparam status_t ST_LOW    = 2'd1;
  localparam status_t ST_HIGH   = 2'd2;
  localparam status_t ST_NONE   = 2'd3;

  localparam count_t  COUNT_RESET = 11'd2;

endpackage

@@ rtl/core/tli_channels.sv @@
interface tli_req_if;
  logic            valid;
  logic            ready;
  logic            opcode;
  tli_pkg::index_t point_index;
  tli_pkg::q16_t   point_x;
  tli_pkg::q16_t   point_y;
  tli_pkg::q16_t   query_value;

  modport source(output valid, opcode, point_index, point_x, point_y, query_value,
                 input ready);
  modport sink(input valid, opcode, point_index, point_x, point_y, query_value,
               output ready);
endinterface

interface tli_rsp_if;
  logic             valid;
  logic             ready;
  tli_pkg::q16_t    result_value;
  tli_pkg::status_t result_status;

  modport source(output valid, result_value, result_status, input ready);
  modport sink(input valid, result_value, result_status, output ready);
endinterface

interface tli_cfg_if;
  logic            valid;
  logic            ready;
  tli_pkg::count_t data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

@@ rtl/core/tli_ram.sv @@
module tli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/tli_div.sv @@
// Restoring divider, one quotient bit per cycle. Needs dividend[63:32] < divisor.
module tli_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  localparam int CNT_W = $clog2(tli_pkg::DIV_STEPS);

  logic [31:0]      rem;
  logic [31:0]      lo;
  logic [31:0]      dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [32:0]      trial;
  logic             ge;
  logic [32:0]      diff;

  always_comb begin
    trial = {rem, lo[31]};
    ge    = trial >= {1'b0, dvs};
    diff  = trial - {1'b0, dvs};
  end

  assign quotient = lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // pulse on the last step
      done <= !start && busy && (cnt == CNT_W'(tli_pkg::DIV_STEPS - 1));
      if (start) begin
        rem  <= dividend[63:32];
        lo   <= dividend[31:0];
        dvs  <= divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[31:0] : trial[31:0];
        lo  <= {lo[30:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(tli_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

@@ rtl/core/table_linear_interpolator.sv @@
// Piecewise linear lookup over a table of up to MAX_POINTS (x, y) points in
// signed Q16.16. A load item (opcode 0) writes one point into two tables
// and leaves the block idle; slots at or above MAX_POINTS are dropped and
// give no result. A query item (opcode 1) gives one result: y[0] with status 1
// when the query is at or below x[0], y[n-1] with status 2 when it is at or
// above x[n-1], otherwise the value interpolated on the lowest segment k with
// x[k] <= v < x[k+1] (status 0), or 0 with status 3 when the table does not
// ascend and no segment holds v. n is point_count clamped to 2..MAX_POINTS.
// A query first reads x[0], which settles a clamp low, and then x[n-1],
// which settles a clamp high. Otherwise the table read port walks the
// points one per cycle (points 1 to k + 1, or up to n - 1 when no segment
// holds v), then a 32x32 multiply follows and the restoring divider holds
// the sequencer (start, 32 steps, done).
// Input ready is held low while a query is in flight; a result that cannot
// leave the full output register adds its stall cycles. A finished result
// sits in the output register while the next loads are accepted. point_count
// may be written at any cycle the block is idle (cfg ready is always high).
module table_linear_interpolator #(
  parameter int MAX_POINTS = tli_pkg::MAX_POINTS_DEF
) (
  input logic  clk,
  input logic  rst,
  tli_cfg_if.sink   cfg,
  tli_req_if.sink   req,
  tli_rsp_if.source rsp
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = (AW + 1 > tli_pkg::COUNT_W) ? AW + 1 : tli_pkg::COUNT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_WAIT, S_LO, S_HI, S_SCAN, S_MUL, S_DIV, S_DONE
  } state_t;

  state_t           state;
  tli_pkg::count_t  point_count;

  // query context
  tli_pkg::q16_t    qv;
  tli_pkg::q16_t    px;       // x of the point before the one on the read port
  tli_pkg::q16_t    py;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    idx;
  logic [AW-1:0]    last;
  logic [31:0]      mag;
  logic [31:0]      t;
  logic [31:0]      dx;
  logic             neg;
  logic [63:0]      prod;
  logic             div_start;
  logic             div_done;
  logic [31:0]      quot;

  tli_pkg::q16_t    res_value;
  tli_pkg::status_t res_status;
  logic             out_valid;
  tli_pkg::q16_t    out_value;
  tli_pkg::status_t out_status;

  // table ports
  logic             wr_en;
  logic [CW-1:0]    idx_wide;
  logic [AW-1:0]    wr_addr;
  logic [31:0]      x_raw;
  logic [31:0]      y_raw;
  tli_pkg::q16_t    x_rd;
  tli_pkg::q16_t    y_rd;

  // active point count, clamped to 2..MAX_POINTS
  logic [CW-1:0]    cnt_wide;
  logic [CW-1:0]    n_act;

  // segment math on the scan cycle
  logic signed [32:0] dy;
  logic signed [32:0] dy_abs;
  logic [32:0]        dx_full;
  logic [32:0]        t_full;
  logic               hit;

  // final sum
  logic signed [33:0] term;
  logic signed [33:0] sum;
  tli_pkg::q16_t      sat_value;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign rsp.valid         = out_valid;
  assign rsp.result_value  = out_value;
  assign rsp.result_status = out_status;

  assign idx_wide = CW'(req.point_index);
  assign wr_addr  = AW'(req.point_index);
  assign wr_en    = req.valid && req.ready && (req.opcode == tli_pkg::OP_LOAD)
                    && (idx_wide < CW'(MAX_POINTS));

  assign x_rd = x_raw;
  assign y_rd = y_raw;

  tli_ram #(.WIDTH(tli_pkg::VAL_W), .DEPTH(MAX_POINTS)) u_xram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (req.point_x),
    .raddr (rd_addr),
    .rdata (x_raw)
  );

  tli_ram #(.WIDTH(tli_pkg::VAL_W), .DEPTH(MAX_POINTS)) u_yram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (req.point_y),
    .raddr (rd_addr),
    .rdata (y_raw)
  );

  tli_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (dx),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    cnt_wide = CW'(point_count);
    if (cnt_wide < CW'(2)) begin
      n_act = CW'(2);
    end else if (cnt_wide > CW'(MAX_POINTS)) begin
      n_act = CW'(MAX_POINTS);
    end else begin
      n_act = cnt_wide;
    end
  end

  always_comb begin
    hit     = (qv >= px) && (qv < x_rd);
    dy      = 33'(y_rd) - 33'(py);
    dy_abs  = dy[32] ? -dy : dy;
    dx_full = 33'(x_rd) - 33'(px);
    t_full  = 33'(qv) - 33'(px);
  end

  always_comb begin
    term = neg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
    sum  = 34'(py) + term;
    // saturate to 32 bits signed
    if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
      sat_value = sum[31:0];
    end else if (sum[33]) begin
      sat_value = {1'b1, {31{1'b0}}};
    end else begin
      sat_value = {1'b0, {31{1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      point_count <= tli_pkg::COUNT_RESET;
      out_valid   <= 1'b0;
      div_start   <= 1'b0;
    end else begin
      // divider starts the cycle after the product is registered
      div_start <= (state == S_MUL);
      if (cfg.valid && cfg.ready) begin
        point_count <= cfg.data;
      end
      // S_DONE refills the register itself when it drains
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid && req.opcode == tli_pkg::OP_QUERY) begin
            qv      <= req.query_value;
            rd_addr <= '0;
            last    <= AW'(n_act - CW'(1));
            state   <= S_WAIT;
          end
        end

        // read of point 0 in flight; queue the last point next
        S_WAIT: begin
          rd_addr <= last;
          state   <= S_LO;
        end

        S_LO: begin
          if (qv <= x_rd) begin
            res_value  <= y_rd;
            res_status <= tli_pkg::ST_LOW;
            state      <= S_DONE;
          end else begin
            px      <= x_rd;
            py      <= y_rd;
            rd_addr <= AW'(1);
            idx     <= AW'(1);
            state   <= S_HI;
          end
        end

        // point 1 read already issued; keep the stream going
        S_HI: begin
          if (qv >= x_rd) begin
            res_value  <= y_rd;
            res_status <= tli_pkg::ST_HIGH;
            state      <= S_DONE;
          end else begin
            rd_addr <= rd_addr + 1'b1;
            state   <= S_SCAN;
          end
        end

        // one point per cycle: read port holds point idx, px/py hold idx-1
        S_SCAN: begin
          if (hit) begin
            neg   <= dy[32];
            mag   <= dy_abs[31:0];
            dx    <= dx_full[31:0];
            t     <= t_full[31:0];
            state <= S_MUL;
          end else if (idx == last) begin
            res_value  <= '0;
            res_status <= tli_pkg::ST_NONE;
            state      <= S_DONE;
          end else begin
            px      <= x_rd;
            py      <= y_rd;
            idx     <= idx + 1'b1;
            rd_addr <= rd_addr + 1'b1;
          end
        end

        // t < dx, so prod[63:32] < dx and the quotient fits 32 bits
        S_MUL: begin
          prod  <= 64'(mag) * 64'(t);
          state <= S_DIV;
        end

        S_DIV: begin
          if (div_done) begin
            res_value  <= sat_value;
            res_status <= tli_pkg::ST_INTERP;
            state      <= S_DONE;
          end
        end

        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_value  <= res_value;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
